/* sv/sflr_pkg.sv */
// shared types and constants for the stereo linear fade ramp
// no dependencies; imported by the controller, the datapath and the top level
package sflr_pkg;

   // gain is unsigned q16, so the ramp quotient has sixteen fraction bits
   localparam int GAIN_FRAC = 16;
   localparam int GAIN_BITS = GAIN_FRAC + 1;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;
   localparam int DIV_CNT_BITS = $clog2(GAIN_FRAC);

   // register map
   localparam int CSR_IDX_BITS = 2;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FADE_BLOCKS  = 2'd0,
      CSR_BLOCK_FRAMES = 2'd1,
      CSR_FADE_OUT     = 2'd2
   } csr_idx_type;

   localparam int FADE_BLOCKS_RST  = 1;
   localparam int BLOCK_FRAMES_RST = 5512;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LEN,
      ST_POS,
      ST_CLAMP,
      ST_DIV,
      ST_GAIN,
      ST_SCALE_L,
      ST_SCALE_R,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic len_mul;
      logic pos_mul;
      logic clamp;
      logic div_step;
      logic gain;
      logic scale_l;
      logic scale_r;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fade_on;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

/* sv/sflr_ctrl.sv */
// sequencing state machine for the stereo linear fade ramp
// depends on sflr_pkg for the state, command and status types
module sflr_ctrl
   import sflr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.fade_on ? ST_LEN : ST_COMMIT;
         end
         ST_LEN: begin
            cmd.len_mul = 1'b1;
            state_in    = ST_POS;
         end
         ST_POS: begin
            cmd.pos_mul = 1'b1;
            state_in    = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_SCALE_L;
         end
         ST_SCALE_L: begin
            cmd.scale_l = 1'b1;
            state_in    = ST_SCALE_R;
         end
         ST_SCALE_R: begin
            cmd.scale_r = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/sflr_datapath.sv */
// ramp counters, shared length multiplier, serial gain divider, sample scaler
// and result register; depends on sflr_pkg for command and status types
module sflr_datapath
   import sflr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [COUNT_BITS-1:0]  fade_blocks,
   input  logic [COUNT_BITS-1:0]  block_frames,
   input  logic                   fade_out,
   input  logic [SAMPLE_BITS-1:0] left_in,
   input  logic [SAMPLE_BITS-1:0] right_in,
   input  logic                   start_fade,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] left_out,
   output logic [SAMPLE_BITS-1:0] right_out,
   output logic                   fading,
   output logic                   fade_last
);

   localparam int CW = COUNT_BITS;
   localparam int SB = SAMPLE_BITS;
   localparam int LW = 2 * CW;
   localparam int PW = SB + GAIN_BITS;

   // ramp state
   logic          ramp_active_ff;
   logic [CW-1:0] blocks_done_ff;
   logic [CW-1:0] frame_in_block_ff;

   // captured frame
   logic [SB-1:0] left_ff;
   logic [SB-1:0] right_ff;
   logic          fade_on_ff;

   // arithmetic registers
   logic [LW-1:0]           len_ff;
   logic [LW-1:0]           pos_ff;
   logic [LW-1:0]           rem_ff;
   logic [GAIN_FRAC-1:0]    quo_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [GAIN_BITS-1:0]    gain_ff;
   logic [SB-1:0]           scl_l_ff;
   logic [SB-1:0]           scl_r_ff;

   // result register
   logic          rsp_valid_ff;
   logic [SB-1:0] left_out_ff;
   logic [SB-1:0] right_out_ff;
   logic          fading_ff;
   logic          fade_last_ff;

   logic [CW-1:0] fb_eff;
   logic [CW-1:0] bf_eff;
   logic [CW-1:0] mul_a;
   logic [LW-1:0] mul_p;
   logic [LW-1:0] pos_sum;
   logic [LW:0]   rem_dbl;
   logic          rem_ge;
   logic          samp_neg;
   logic [SB-1:0] samp_sel;
   logic [SB-1:0] samp_mag;
   logic [PW-1:0] scl_p;
   logic          block_end;
   logic          last;
   logic [SB-1:0] left_res;
   logic [SB-1:0] right_res;

   // zero length registers count as one
   assign fb_eff = (fade_blocks == '0) ? CW'(1) : fade_blocks;
   assign bf_eff = (block_frames == '0) ? CW'(1) : block_frames;

   // one multiplier serves both the ramp length and the block offset
   assign mul_a   = cmd.len_mul ? fb_eff : blocks_done_ff;
   assign mul_p   = LW'(mul_a) * LW'(bf_eff);
   assign pos_sum = pos_ff + LW'(frame_in_block_ff);

   // restoring division, one quotient bit per cycle
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, len_ff});

   // sign and magnitude of the channel being scaled
   assign samp_sel = cmd.scale_r ? right_ff : left_ff;
   assign samp_neg = samp_sel[SB-1];
   assign samp_mag = samp_neg ? (SB'(0) - samp_sel) : samp_sel;
   assign scl_p    = PW'(samp_mag) * PW'(gain_ff);

   assign block_end = ({1'b0, frame_in_block_ff} + (CW+1)'(1)) >= {1'b0, bf_eff};
   assign last      = block_end
                   && (({1'b0, blocks_done_ff} + (CW+1)'(1)) >= {1'b0, fb_eff});

   assign left_res  = left_ff[SB-1]  ? (SB'(0) - scl_l_ff) : scl_l_ff;
   assign right_res = right_ff[SB-1] ? (SB'(0) - scl_r_ff) : scl_r_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      if (cmd.len_mul) begin
         len_ff <= mul_p;
      end
      if (cmd.pos_mul) begin
         pos_ff <= mul_p;
      end
      if (cmd.clamp) begin
         // position at or past the end uses the final step
         rem_ff <= (pos_sum >= len_ff) ? (len_ff - LW'(1)) : pos_sum;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? LW'(rem_dbl - {1'b0, len_ff}) : LW'(rem_dbl);
         quo_ff <= {quo_ff[GAIN_FRAC-2:0], rem_ge};
      end
      if (cmd.gain) begin
         gain_ff <= fade_out ? (GAIN_ONE - {1'b0, quo_ff}) : {1'b0, quo_ff};
      end
      if (cmd.scale_l) begin
         scl_l_ff <= scl_p[GAIN_FRAC +: SB];
      end
      if (cmd.scale_r) begin
         scl_r_ff <= scl_p[GAIN_FRAC +: SB];
      end
      if (cmd.commit) begin
         left_out_ff  <= fade_on_ff ? left_res  : left_ff;
         right_out_ff <= fade_on_ff ? right_res : right_ff;
         fading_ff    <= fade_on_ff;
         fade_last_ff <= fade_on_ff && last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_active_ff    <= 1'b0;
         blocks_done_ff    <= '0;
         frame_in_block_ff <= '0;
         fade_on_ff        <= 1'b0;
         div_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (cmd.capture) begin
            fade_on_ff <= ramp_active_ff | start_fade;
         end
         if (cmd.clamp) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_BITS'(1);
         end
         if (cmd.commit && fade_on_ff) begin
            if (last) begin
               ramp_active_ff    <= 1'b0;
               blocks_done_ff    <= '0;
               frame_in_block_ff <= '0;
            end else if (block_end) begin
               ramp_active_ff    <= 1'b1;
               blocks_done_ff    <= blocks_done_ff + CW'(1);
               frame_in_block_ff <= '0;
            end else begin
               ramp_active_ff    <= 1'b1;
               frame_in_block_ff <= frame_in_block_ff + CW'(1);
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.fade_on  = fade_on_ff;
   assign stat.div_last = (div_cnt_ff == DIV_CNT_BITS'(GAIN_FRAC - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign left_out  = left_out_ff;
   assign right_out = right_out_ff;
   assign fading    = fading_ff;
   assign fade_last = fade_last_ff;

endmodule

/* sv/stereo_linear_fade_ramp_top.sv */
// top level of the stereo linear fade ramp: control registers and the
// controller and datapath; depends on sflr_pkg, sflr_ctrl and sflr_datapath

// Stereo linear fade ramp. Each transfer on the req_ channel carries one
// signed stereo frame and a start_fade flag; each produces exactly one
// transfer on the rsp_ channel. While a fade runs both channels are scaled
// by a q16 gain floor(p*65536/L), p the frame position in the ramp and L
// fade_blocks*block_frames frames (65536 minus that when fade_out is set),
// truncated toward zero. The last ramp frame has rsp_fade_last set and ends
// the fade; outside a fade frames pass unchanged with rsp_fading low.
// start_fade begins a fade only when none is running, and that frame is
// position zero. A frame inside a fade is computed step by step, and the
// next frame is not taken until it has been committed: the ramp length
// and block offset share one multiplier, the gain divider produces one
// quotient bit per cycle, and one sample multiplier handles left then
// right; a pass-through frame skips to its commit. The result sits in
// an output register, so the next frame is taken while a result waits; a
// frame only stalls at its last step if the previous result has not been
// taken. Registers are written through csr_write_en/csr_index/csr_wdata
// with no wait state and should only change while the block is idle; a
// zero fade_blocks or block_frames acts as one.
module stereo_linear_fade_ramp_top
   import sflr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [COUNT_BITS-1:0]         csr_wdata,
   // frame input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  logic                          req_start_fade,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_fading,
   output logic                          rsp_fade_last
);

   // control registers
   logic [COUNT_BITS-1:0] fade_blocks_ff;
   logic [COUNT_BITS-1:0] block_frames_ff;
   logic                  fade_out_ff;

   cmd_type  cmd;
   stat_type stat;

   logic [SAMPLE_BITS-1:0] left_out_w;
   logic [SAMPLE_BITS-1:0] right_out_w;

   // register writes, unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_blocks_ff  <= COUNT_BITS'(FADE_BLOCKS_RST);
         block_frames_ff <= COUNT_BITS'(BLOCK_FRAMES_RST);
         fade_out_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FADE_BLOCKS: begin
               fade_blocks_ff <= csr_wdata;
            end
            CSR_BLOCK_FRAMES: begin
               block_frames_ff <= csr_wdata;
            end
            CSR_FADE_OUT: begin
               fade_out_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencing of one frame through the datapath
   sflr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counters, divider, scaler and result register
   sflr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .fade_blocks  (fade_blocks_ff),
      .block_frames (block_frames_ff),
      .fade_out     (fade_out_ff),
      .left_in      (req_left_in),
      .right_in     (req_right_in),
      .start_fade   (req_start_fade),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .left_out     (left_out_w),
      .right_out    (right_out_w),
      .fading       (rsp_fading),
      .fade_last    (rsp_fade_last)
   );

   assign rsp_left_out  = left_out_w;
   assign rsp_right_out = right_out_w;

endmodule
